### rtl/qri_pkg.sv
package qri_pkg;

  localparam logic [31:0] STEP_TIME_RST = 32'd21474836;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam int CORDIC_STEPS = 30;
  localparam int QUEUE_DEPTH_DEF = 2;

  // one queued integration step
  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic               frame;
    logic               zero;
  } qri_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_PMUL, ST_KLO, ST_KHI,
    ST_CORDIC, ST_SMUL, ST_DIV, ST_QMUL, ST_OUT
  } qri_state_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // sign of Hamilton product term j of component k; attitude index is k ^ j
  function automatic logic term_neg(input logic [1:0] k, input logic [1:0] j,
                                    input logic inertial);
    logic [3:0] m;
    case (k)
      2'd0: m = 4'b1110;
      2'd1: m = inertial ? 4'b1000 : 4'b0100;
      2'd2: m = inertial ? 4'b0010 : 4'b1000;
      default: m = inertial ? 4'b0100 : 4'b0010;
    endcase
    return m[j];
  endfunction

endpackage

### rtl/qri_front.sv
module qri_front import qri_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_omega_x,
  input  logic signed [31:0] in_omega_y,
  input  logic signed [31:0] in_omega_z,
  input  logic               in_frame,
  output logic               push,
  output qri_item_t          push_item,
  input  logic               q_full
);

  logic      valid_r, valid_nxt;
  qri_item_t item_r;

  assign push      = valid_r && !q_full;
  assign in_ready  = !valid_r || push;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) valid_nxt = 1'b0;
    if (in_valid && in_ready) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // capture and classify: an all-zero rate means an identity increment
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.wx    <= in_omega_x;
      item_r.wy    <= in_omega_y;
      item_r.wz    <= in_omega_z;
      item_r.frame <= in_frame;
      item_r.zero  <= (in_omega_x == 32'sd0) && (in_omega_y == 32'sd0) &&
                      (in_omega_z == 32'sd0);
    end
  end

endmodule

### rtl/qri_queue.sv
module qri_queue import qri_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  qri_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output qri_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qri_item_t       mem [DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### rtl/qri_back.sv
module qri_back import qri_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        step_time,
  input  logic               q_empty,
  input  qri_item_t          q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z
);

  qri_state_t state_r, state_nxt;
  logic [4:0]  cnt_r;
  logic [1:0]  comp_r;
  qri_item_t   item_r;

  logic [63:0] n_r, res_r;
  logic [31:0] norm_r;
  logic [63:0] p_r;
  logic [61:0] a_r;
  logic [1:0]  quad_r;
  logic signed [33:0] x_r, y_r, z_r, s_r;
  logic [32:0] rem_r;
  logic [31:0] dvd_r;
  logic signed [32:0] e_r [4];
  logic signed [31:0] att_r [4];
  logic signed [31:0] qn_r [4];
  logic signed [65:0] acc_r;
  logic        out_valid_r;
  logic signed [31:0] oq_r [4];

  logic last_cnt, load_out;

  assign out_valid  = out_valid_r;
  assign out_quat_w = oq_r[0];
  assign out_quat_x = oq_r[1];
  assign out_quat_y = oq_r[2];
  assign out_quat_z = oq_r[3];

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (!q_empty) state_nxt = q_item.zero ? ST_QMUL : ST_SQ;
      ST_SQ:     if (cnt_r == 5'd2) state_nxt = ST_SQRT;
      ST_SQRT:   if (cnt_r == 5'd31) state_nxt = ST_PMUL;
      ST_PMUL:   state_nxt = ST_KLO;
      ST_KLO:    state_nxt = ST_KHI;
      ST_KHI:    state_nxt = ST_CORDIC;
      ST_CORDIC: if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_SMUL;
      ST_SMUL:   state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 5'd31) state_nxt = (comp_r == 2'd2) ? ST_QMUL : ST_SMUL;
      ST_QMUL:   if (comp_r == 2'd3 && cnt_r[1:0] == 2'd3) state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    last_cnt = (state_nxt != state_r);
    case (state_r)
      ST_IDLE: pop = !q_empty;
      ST_OUT:  load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
      att_r[0]    <= 32'(ONE_Q30);
      att_r[1]    <= '0;
      att_r[2]    <= '0;
      att_r[3]    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE || last_cnt) cnt_r <= '0;
      else cnt_r <= cnt_r + 1'b1;
      if (state_r == ST_IDLE) comp_r <= '0;
      // last division wraps the component back to w for the product
      else if (state_r == ST_DIV && cnt_r == 5'd31)
        comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 1'b1;
      else if (state_r == ST_QMUL && cnt_r[1:0] == 2'd3) comp_r <= comp_r + 1'b1;
      else if (state_r == ST_CORDIC) comp_r <= '0;
      if (load_out) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 4; i++) att_r[i] <= qn_r[i];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  logic [31:0] sq_mag;
  logic [63:0] sq_prod, sq_bit, sq_trial;
  logic [61:0] kb_prod;
  logic [63:0] top;
  logic [31:0] turns, ru;
  logic [1:0]  quad;
  logic signed [33:0] xn, yn, zn, atan_ext;
  logic [31:0] s_mag, o_mag;
  logic [63:0] so_prod;
  logic [32:0] dv_t;
  logic        dv_q;
  logic [1:0]  qk, qj;
  logic signed [64:0] q_prod;
  logic signed [65:0] q_tot;
  logic signed [35:0] q_rnd;
  logic signed [31:0] q_sat;
  logic signed [31:0] om_sel;
  logic [1:0]  om_idx;

  always_comb begin
    // sum of squares walks the axes by count, scaling by component
    om_idx = (state_r == ST_SQ) ? cnt_r[1:0] : comp_r;
    case (om_idx)
      2'd0:    om_sel = item_r.wx;
      2'd1:    om_sel = item_r.wy;
      default: om_sel = item_r.wz;
    endcase
    sq_mag   = mag32(om_sel);
    sq_prod  = sq_mag * sq_mag;
    sq_bit   = 64'd1 << (7'd62 - {1'b0, cnt_r, 1'b0});
    sq_trial = res_r + sq_bit;
    kb_prod  = p_r[63:32] * INV_TWO_PI_Q32;
    top      = {2'b00, kb_prod} + {34'd0, a_r[61:32]};
    turns    = top[48:17];
    quad     = 2'((turns + 32'h2000_0000) >> 30);
    ru       = turns - {quad, 30'd0};
    atan_ext = {4'd0, atan_turn(cnt_r)};
    if (!z_r[33]) begin
      xn = x_r - (y_r >>> cnt_r);
      yn = y_r + (x_r >>> cnt_r);
      zn = z_r - atan_ext;
    end else begin
      xn = x_r + (y_r >>> cnt_r);
      yn = y_r - (x_r >>> cnt_r);
      zn = z_r + atan_ext;
    end
    s_mag   = s_r[33] ? 32'(-s_r) : 32'(s_r);
    o_mag   = mag32(om_sel);
    so_prod = s_mag * o_mag;
    dv_t    = {rem_r[31:0], dvd_r[31]};
    dv_q    = (dv_t >= {1'b0, norm_r});
    qk      = comp_r;
    qj      = cnt_r[1:0];
    q_prod  = att_r[qk ^ qj] * e_r[qj];
    q_tot   = term_neg(qk, qj, item_r.frame) ? acc_r - 66'(q_prod) : acc_r + 66'(q_prod);
    q_rnd   = 36'((q_tot + 66'sd536870912) >>> 30);
    if (q_rnd > 36'sd2147483647) q_sat = 32'sh7fff_ffff;
    else if (q_rnd < -36'sd2147483648) q_sat = 32'sh8000_0000;
    else q_sat = q_rnd[31:0];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r <= q_item;
        n_r    <= '0;
        res_r  <= '0;
        acc_r  <= '0;
        e_r[0] <= ONE_Q30;
        e_r[1] <= '0;
        e_r[2] <= '0;
        e_r[3] <= '0;
      end
      // sum of squares, one axis a cycle
      ST_SQ: n_r <= n_r + sq_prod;
      // integer square root, one result bit a cycle
      ST_SQRT: begin
        if (n_r >= sq_trial) begin
          n_r   <= n_r - sq_trial;
          res_r <= (res_r >> 1) + sq_bit;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      ST_PMUL: begin
        norm_r <= res_r[31:0];
        p_r    <= step_time * res_r[31:0];
      end
      ST_KLO: a_r <= p_r[31:0] * INV_TWO_PI_Q32;
      // phase in turns, quadrant split and rotator seed
      ST_KHI: begin
        quad_r <= quad;
        z_r    <= {{2{ru[31]}}, ru};
        x_r    <= CORDIC_GAIN_Q30;
        y_r    <= '0;
      end
      ST_CORDIC: begin
        x_r <= xn;
        y_r <= yn;
        z_r <= zn;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          case (quad_r)
            2'd0: begin e_r[0] <= 33'(xn);  s_r <= yn;  end
            2'd1: begin e_r[0] <= 33'(-yn); s_r <= xn;  end
            2'd2: begin e_r[0] <= 33'(-xn); s_r <= -yn; end
            default: begin e_r[0] <= 33'(yn); s_r <= -xn; end
          endcase
        end
      end
      ST_SMUL: begin
        rem_r <= {1'b0, so_prod[63:32]};
        dvd_r <= so_prod[31:0];
      end
      // restoring division, quotient shifts in at the bottom
      ST_DIV: begin
        rem_r <= dv_q ? dv_t - {1'b0, norm_r} : dv_t;
        dvd_r <= {dvd_r[30:0], dv_q};
        if (cnt_r == 5'd31) begin
          if (s_r[33] != om_sel[31])
            e_r[comp_r + 2'd1] <= -$signed({1'b0, dvd_r[30:0], dv_q});
          else
            e_r[comp_r + 2'd1] <= $signed({1'b0, dvd_r[30:0], dv_q});
        end
      end
      // Hamilton product, one term a cycle
      ST_QMUL: begin
        if (cnt_r[1:0] == 2'd3) begin
          acc_r      <= '0;
          qn_r[qk]   <= q_sat;
        end else begin
          acc_r <= q_tot;
        end
      end
      ST_OUT: if (load_out) for (int i = 0; i < 4; i++) oq_r[i] <= qn_r[i];
      default: ;
    endcase
  end

endmodule

### rtl/quaternion_rate_integrator_core.sv
// Quaternion rate integrator, exponential update.
// Input channel (in_valid/in_ready): one integration step per item, angular
// rate in Q16.16 rad/s and a frame bit (0 body, 1 inertial).
// Output channel (out_valid/out_ready): the updated attitude, Q2.30, one item
// per input item, in order.
// cfg_wr_en/cfg_wr_data write the step time (unsigned Q0.32 s) at any edge.
// For a nonzero rate the sequencer runs a sum of squares over the three axes,
// 32 square-root iterations, the phase computation, 30 CORDIC steps, three
// divisions and a quaternion product. A zero rate goes straight to the
// product. The front stage and a short queue take new items while the
// sequencer works.
// Reset (synchronous, rst_n low): attitude returns to identity, step time to
// 1/200 s, queue and output emptied.
// When the receiver stalls, the result holds in the output register; the
// sequencer waits only when it has a second result ready.
module quaternion_rate_integrator_core import qri_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_omega_x,
  input  logic signed [31:0] in_omega_y,
  input  logic signed [31:0] in_omega_z,
  input  logic               in_frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  logic [31:0] step_time_r;
  logic        push, q_full, pop, q_empty;
  qri_item_t   push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= STEP_TIME_RST;
    end else if (cfg_wr_en) begin
      step_time_r <= cfg_wr_data;
    end
  end

  qri_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_omega_x, .in_omega_y, .in_omega_z,
    .in_frame, .push, .push_item, .q_full
  );

  qri_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .push_item, .full(q_full), .pop, .empty(q_empty),
    .pop_item
  );

  qri_back u_back (
    .clk, .rst_n, .step_time(step_time_r), .q_empty, .q_item(pop_item), .pop,
    .out_valid, .out_ready, .out_quat_w, .out_quat_x, .out_quat_y, .out_quat_z
  );

endmodule

### rtl/qri_checker.sv
module qri_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_quat_w,
  input logic signed [31:0] out_quat_x
);

  // reset empties the output and opens the input
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("output not empty or input closed after reset");

  // an offered result carries known data
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_quat_w, out_quat_x}))
    else $error("unknown result data");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_w) && $stable(out_quat_x))
    else $error("stalled result changed");

endmodule

bind quaternion_rate_integrator_core qri_checker u_qri_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_quat_w, .out_quat_x
);

### tb/quaternion_rate_integrator_core_tb.sv
module quaternion_rate_integrator_core_tb;
  import qri_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int HOLD_CYCLES    = 3000;

  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic               frame;
  } rate_item_t;

  typedef struct {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  // arctangent of 2^-i in 2^-32 turn units
  localparam longint ATAN_TURNS [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_omega_x = '0;
  logic signed [31:0] in_omega_y = '0;
  logic signed [31:0] in_omega_z = '0;
  logic               in_frame = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_quat_w;
  logic signed [31:0] out_quat_x;
  logic signed [31:0] out_quat_y;
  logic signed [31:0] out_quat_z;
  logic               cfg_wr_en = 1'b0;
  logic [31:0]        cfg_wr_data = '0;

  // testbench state
  rate_item_t   pending_rates[$];
  quat_t        expected_attitudes[$];
  rate_item_t   shown_rate;
  quat_t        model_att;
  logic [31:0]  model_step;
  int           idle_mode = 2;
  logic         sender_pause = 1'b0;
  logic         start_hold = 1'b0;
  int           hold_left = 0;
  int           idle_run = 0;
  int           n_steps = 0;
  int           n_updates = 0;
  int           n_mismatch = 0;
  int           n_inertial = 0;
  int           n_zero_rate = 0;

  quaternion_rate_integrator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_omega_x (in_omega_x),
    .in_omega_y (in_omega_y),
    .in_omega_z (in_omega_z),
    .in_frame   (in_frame),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_quat_w (out_quat_w),
    .out_quat_x (out_quat_x),
    .out_quat_y (out_quat_y),
    .out_quat_z (out_quat_z),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // integer square root, floor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // CORDIC cosine and sine of a Q0.32 turn count, Q2.30
  task automatic cos_sin_turns(input logic [31:0] t, output longint c, output longint s);
    logic [31:0] sum;
    logic [1:0]  quad;
    logic [31:0] ru;
    longint      x, y, z, dx, dy;
    sum = t + 32'h2000_0000;
    quad = sum[31:30];
    ru = t - {quad, 30'b0};
    z = longint'(signed'(ru));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // sin * omega / |omega|, truncated toward zero
  function automatic longint axis_part(input longint s, input longint om,
                                       input logic [63:0] norm);
    logic [63:0] ms, mo, q;
    ms = (s < 0) ? -s : s;
    mo = (om < 0) ? -om : om;
    q = (ms * mo) / norm;
    return ((s < 0) != (om < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // sum of four Q4.60 terms, rounded to Q2.30 and clamped
  function automatic logic signed [31:0] round_clamp(input longint a, input longint b,
                                                     input longint c, input longint d);
    logic signed [79:0] acc;
    logic signed [79:0] r;
    acc = a;
    acc = acc + b;
    acc = acc + c;
    acc = acc + d;
    r = (acc + 80'sd536870912) >>> 30;
    if (r > 80'sd2147483647) return 32'h7fff_ffff;
    if (r < -80'sd2147483648) return 32'h8000_0000;
    return r[31:0];
  endfunction

  // one integration step of the attitude
  task automatic integrate_step(input rate_item_t it);
    longint      om[3];
    longint      ew, ex, ey, ez, c, s;
    longint      qw, qx, qy, qz;
    logic [63:0] sumsq, norm, m, p;
    logic [127:0] prod;
    logic [31:0] turns;
    quat_t       nq;
    om[0] = it.wx; om[1] = it.wy; om[2] = it.wz;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      m = (om[i] < 0) ? -om[i] : om[i];
      sumsq = sumsq + m * m;
    end
    norm = floor_sqrt(sumsq);
    if (norm == 0) begin
      ew = 1073741824; ex = 0; ey = 0; ez = 0;
    end else begin
      p = 64'(model_step) * norm;
      prod = 128'(p) * 128'(INV_TWO_PI_Q32);
      turns = prod[80:49];
      cos_sin_turns(turns, c, s);
      ew = c;
      ex = axis_part(s, om[0], norm);
      ey = axis_part(s, om[1], norm);
      ez = axis_part(s, om[2], norm);
    end
    qw = model_att.w; qx = model_att.x; qy = model_att.y; qz = model_att.z;
    nq.w = round_clamp(qw * ew, -(qx * ex), -(qy * ey), -(qz * ez));
    if (!it.frame) begin
      nq.x = round_clamp(qx * ew, qw * ex, -(qz * ey), qy * ez);
      nq.y = round_clamp(qy * ew, qz * ex, qw * ey, -(qx * ez));
      nq.z = round_clamp(qz * ew, -(qy * ex), qx * ey, qw * ez);
    end else begin
      nq.x = round_clamp(ew * qx, ex * qw, ey * qz, -(ez * qy));
      nq.y = round_clamp(ew * qy, -(ex * qz), ey * qw, ez * qx);
      nq.z = round_clamp(ew * qz, ex * qy, -(ey * qx), ez * qw);
    end
    model_att = nq;
    expected_attitudes.push_back(nq);
    if (norm == 0) n_zero_rate++;
    if (it.frame) n_inertial++;
  endtask

  // driver: present queued items, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        integrate_step(shown_rate);
        n_steps++;
      end
      if (!in_valid || in_ready) begin
        if (pending_rates.size() != 0 && !sender_pause &&
            !(idle_mode == 0 && $urandom_range(0, 99) < 33) &&
            !(idle_mode == 1 && $urandom_range(0, 99) < 54)) begin
          shown_rate = pending_rates.pop_front();
          in_omega_x <= shown_rate.wx;
          in_omega_y <= shown_rate.wy;
          in_omega_z <= shown_rate.wz;
          in_frame   <= shown_rate.frame;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (start_hold) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (start_hold || hold_left > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_mode == 0 && $urandom_range(0, 99) < 54) &&
                   !(idle_mode == 1 && $urandom_range(0, 99) < 33);
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    quat_t want;
    if (rst_n && out_valid && out_ready) begin
      n_updates++;
      if (expected_attitudes.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result w=%0d x=%0d y=%0d z=%0d",
                   out_quat_w, out_quat_x, out_quat_y, out_quat_z);
      end else begin
        want = expected_attitudes.pop_front();
        if (out_quat_w !== want.w || out_quat_x !== want.x ||
            out_quat_y !== want.y || out_quat_z !== want.z) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result %0d: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                     n_updates, want.w, want.x, want.y, want.z,
                     out_quat_w, out_quat_x, out_quat_y, out_quat_z);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without progress", idle_run);
      $display("status: fail");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  function automatic rate_item_t make_rate(input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic signed [31:0] z,
                                           input logic f);
    rate_item_t it;
    it.wx = x; it.wy = y; it.wz = z; it.frame = f;
    return it;
  endfunction

  function automatic logic signed [31:0] edge_value();
    case ($urandom_range(0, 4))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_rate(input int kind);
    case (kind)
      0: return signed'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      1: return signed'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      2: return signed'($urandom());
      default: return edge_value();
    endcase
  endfunction

  function automatic rate_item_t random_rate();
    int kind;
    int sel;
    rate_item_t it;
    sel = $urandom_range(0, 19);
    kind = (sel < 9) ? 0 : (sel < 13) ? 1 : (sel < 17) ? 2 : 3;
    it = make_rate(rand_rate(kind), rand_rate(kind), rand_rate(kind),
                   1'($urandom_range(0, 1)));
    // single-axis and zero-rate steps
    if (sel == 17) begin
      it.wy = 0; it.wz = 0;
    end else if (sel == 18) begin
      it.wx = 0; it.wy = 0; it.wz = 0;
    end
    return it;
  endfunction

  task automatic write_step_time(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    model_step = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_rates.size() != 0 || in_valid || expected_attitudes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int mode, input logic [31:0] step);
    write_step_time(step);
    idle_mode = mode;
    for (int i = 0; i < count; i++) pending_rates.push_back(random_rate());
  endtask

  initial begin
    model_att.w = 32'sd1073741824;
    model_att.x = 0; model_att.y = 0; model_att.z = 0;
    model_step = STEP_TIME_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed steps at the reset step time
    idle_mode = 2;
    pending_rates.push_back(make_rate(0, 0, 0, 0));
    pending_rates.push_back(make_rate(1, 0, 0, 0));
    pending_rates.push_back(make_rate(0, -1, 0, 1));
    pending_rates.push_back(make_rate(0, 0, 32'sh0001_0000, 0));
    pending_rates.push_back(make_rate(32'sh7fff_ffff, 0, 0, 0));
    pending_rates.push_back(make_rate(0, 32'sh8000_0000, 0, 1));
    pending_rates.push_back(make_rate(0, 0, 32'sh8000_0000, 0));
    pending_rates.push_back(make_rate(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0));
    pending_rates.push_back(make_rate(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1));
    pending_rates.push_back(make_rate(32'sh8000_0000, 32'sh7fff_ffff, -1, 0));
    pending_rates.push_back(make_rate(0, 0, 0, 1));
    pending_rates.push_back(make_rate(32'sh0003_2000, -32'sh0001_8000, 32'sh0000_4000, 1));
    pending_rates.push_back(make_rate(32'sh0003_2000, -32'sh0001_8000, 32'sh0000_4000, 0));
    pending_rates.push_back(make_rate(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 1));
    pending_rates.push_back(make_rate(32'shaaaa_aaaa, 32'sh5555_5555, 32'shf0f0_f0f0, 0));
    wait_drained();

    // longest step time, big phase wrap; receiver held off once
    random_phase(200, 0, 32'hffff_ffff);
    repeat (20) @(posedge clk);
    start_hold <= 1'b1;
    @(posedge clk);
    start_hold <= 1'b0;
    wait_drained();

    // shortest step time
    random_phase(200, 1, 32'd1);
    wait_drained();

    random_phase(300, 2, $urandom_range(1, 32'hffff_ffff));
    // sender pauses until all results are back, then resumes
    sender_pause = 1'b1;
    repeat (50) @(posedge clk);
    while (in_valid || expected_attitudes.size() != 0) @(posedge clk);
    sender_pause = 1'b0;
    wait_drained();

    random_phase(300, 0, $urandom());
    wait_drained();

    random_phase(300, 1, STEP_TIME_RST);
    wait_drained();

    $display("ran %0d integration steps (%0d inertial, %0d zero rate), %0d updates checked",
             n_steps, n_inertial, n_zero_rate, n_updates);
    $display("step times covered: reset, 1, max and random; %0d mismatches", n_mismatch);
    if (n_mismatch == 0 && expected_attitudes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
